/* sv/yuv420_supercover_line_defines.svh */
// Assertion macros shared by the supercover line generator.
`ifndef YUV420_SUPERCOVER_LINE_DEFINES_SVH
`define YUV420_SUPERCOVER_LINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define YSL_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define YSL_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ysl_pkg.sv */
// Types and constants shared by the supercover line generator.
`timescale 1ns / 1ps

package ysl_pkg;

    localparam int COORD_W     = 13;
    localparam int ERR_W       = 16;
    localparam int ADDR_W      = 25;
    localparam int COLOR_W     = 24;
    localparam int PTS         = 3;
    localparam int CNT_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 128;

    localparam logic [COORD_W-1:0] MAX_DIM      = 13'd4096;
    localparam logic [COORD_W-1:0] RESET_WIDTH  = 13'd352;
    localparam logic [COORD_W-1:0] RESET_HEIGHT = 13'd288;
    localparam logic [ADDR_W-1:0]  RESET_SIZE   = 25'd101376;
    localparam logic [ADDR_W-1:0]  RESET_VBASE  = 25'd126720;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        KIND_POINT  = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_REJECT = 3'd2,
        KIND_IDLE   = 3'd3,
        KIND_FINISH = 3'd4
    } kind_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    // one classified input item: its kind and the points it writes
    typedef struct packed {
        kind_t                          kind;
        logic [CNT_W-1:0]               cnt;
        logic [PTS-1:0][COORD_W-1:0]    px;
        logic [PTS-1:0][COORD_W-1:0]    py;
        logic [COLOR_W-1:0]             color;
    } job_t;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [ADDR_W-1:0]  size;
        logic [ADDR_W-1:0]  vbase;
    } geom_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } queue_stat_t;

endpackage

/* sv/ysl_front.sv */
// Front end: accepts items, keeps the line state and classifies each step.
`timescale 1ns / 1ps

module ysl_front import ysl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // start_x, start_y, end_x, end_y, luma_in, cb_in, cr_in, zero pad
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                    s_axis_tuser,
    input  geom_t                   geom,
    input  queue_stat_t             q_stat,
    output logic                    push,
    output job_t                    push_job
);

    logic                   active_reg, active_next;
    logic [COORD_W-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic [COORD_W-1:0]     steps_reg, steps_next;
    logic [ERR_W-1:0]       errn_reg, errn_next, errp_reg, errp_next;
    logic [COORD_W-1:0]     dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic                   xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic                   xmaj_reg, xmaj_next;
    logic [COLOR_W-1:0]     color_reg, color_next;

    logic                   accept;
    logic [COORD_W-1:0]     sx, sy, ex, ey;
    logic                   ld_xneg, ld_yneg, ld_xmaj, ld_reject;
    logic [COORD_W-1:0]     ld_dx, ld_dy;

    logic [COORD_W:0]       two_maj, two_min;
    logic [ERR_W-1:0]       e1, e2;
    logic [ERR_W:0]         err_sum;
    logic                   diag, c_min, c_maj;
    logic [COORD_W-1:0]     mx, my, nx, ny;
    logic [COORD_W-1:0]     mb_x, mb_y, jb_x, jb_y;

    function automatic logic [COORD_W-1:0] move_coord(input logic [COORD_W-1:0] v,
                                                      input logic neg);
        return neg ? v - 1'b1 : v + 1'b1;
    endfunction

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept;

    assign sx = s_axis_tdata[12:0];
    assign sy = s_axis_tdata[25:13];
    assign ex = s_axis_tdata[38:26];
    assign ey = s_axis_tdata[51:39];

    // load: bounds check, direction and major axis
    assign ld_reject = (sx > geom.width) || (ex > geom.width) ||
                       (sy > geom.height) || (ey > geom.height);
    assign ld_xneg   = ex < sx;
    assign ld_yneg   = ey < sy;
    assign ld_dx     = ld_xneg ? sx - ex : ex - sx;
    assign ld_dy     = ld_yneg ? sy - ey : ey - sy;
    assign ld_xmaj   = ld_dx >= ld_dy;

    // step: doubled-delta error, diagonal test and corner selection
    assign two_maj = {dmaj_reg, 1'b0};
    assign two_min = {dmin_reg, 1'b0};
    assign e1      = errn_reg + {{(ERR_W-COORD_W-1){1'b0}}, two_min};
    assign diag    = e1 > {{(ERR_W-COORD_W-1){1'b0}}, two_maj};
    assign e2      = e1 - {{(ERR_W-COORD_W-1){1'b0}}, two_maj};
    assign err_sum = {1'b0, e2} + {1'b0, errp_reg};
    assign c_min   = err_sum <= {{(ERR_W-COORD_W){1'b0}}, two_maj};
    assign c_maj   = err_sum >= {{(ERR_W-COORD_W){1'b0}}, two_maj};

    assign mx = move_coord(cx_reg, xneg_reg);
    assign my = move_coord(cy_reg, yneg_reg);
    assign nx = (xmaj_reg || diag)  ? mx : cx_reg;
    assign ny = (!xmaj_reg || diag) ? my : cy_reg;

    // minor-back corner: major new, minor old; major-back: the other way round
    assign mb_x = xmaj_reg ? nx : cx_reg;
    assign mb_y = xmaj_reg ? cy_reg : ny;
    assign jb_x = xmaj_reg ? cx_reg : nx;
    assign jb_y = xmaj_reg ? ny : cy_reg;

    always_comb
    begin
        active_next = active_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        steps_next  = steps_reg;
        errn_next   = errn_reg;
        errp_next   = errp_reg;
        dmaj_next   = dmaj_reg;
        dmin_next   = dmin_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        xmaj_next   = xmaj_reg;
        color_next  = color_reg;
        push_job    = '0;
        push_job.kind = KIND_IDLE;
        push_job.cnt  = 2'd1;
        if (accept)
        begin
            if (action_t'(s_axis_tuser) == ACT_LOAD)
            begin
                if (ld_reject)
                begin
                    active_next   = 1'b0;
                    push_job.kind = KIND_REJECT;
                end
                else
                begin
                    active_next   = 1'b1;
                    xneg_next     = ld_xneg;
                    yneg_next     = ld_yneg;
                    xmaj_next     = ld_xmaj;
                    dmaj_next     = ld_xmaj ? ld_dx : ld_dy;
                    dmin_next     = ld_xmaj ? ld_dy : ld_dx;
                    errn_next     = {{(ERR_W-COORD_W){1'b0}}, dmaj_next};
                    errp_next     = {{(ERR_W-COORD_W){1'b0}}, dmaj_next};
                    steps_next    = dmaj_next;
                    cx_next       = sx;
                    cy_next       = sy;
                    // luma in the top byte, then U, then V
                    color_next    = {s_axis_tdata[59:52], s_axis_tdata[67:60],
                                     s_axis_tdata[75:68]};
                    push_job.kind = KIND_ACCEPT;
                end
            end
            else if (!active_reg)
            begin
                push_job.kind = KIND_IDLE;
            end
            else if (steps_reg == '0)
            begin
                active_next   = 1'b0;
                push_job.kind = KIND_FINISH;
            end
            else
            begin
                cx_next        = nx;
                cy_next        = ny;
                errn_next      = diag ? e2 : e1;
                errp_next      = diag ? e2 : e1;
                steps_next     = steps_reg - 1'b1;
                push_job.kind  = KIND_POINT;
                push_job.color = color_reg;
                push_job.px[0] = nx;
                push_job.py[0] = ny;
                if (diag)
                begin
                    if (c_min && c_maj)
                    begin
                        push_job.cnt   = 2'd3;
                        push_job.px[0] = mb_x;
                        push_job.py[0] = mb_y;
                        push_job.px[1] = jb_x;
                        push_job.py[1] = jb_y;
                        push_job.px[2] = nx;
                        push_job.py[2] = ny;
                    end
                    else if (c_min)
                    begin
                        push_job.cnt   = 2'd2;
                        push_job.px[0] = mb_x;
                        push_job.py[0] = mb_y;
                        push_job.px[1] = nx;
                        push_job.py[1] = ny;
                    end
                    else
                    begin
                        push_job.cnt   = 2'd2;
                        push_job.px[0] = jb_x;
                        push_job.py[0] = jb_y;
                        push_job.px[1] = nx;
                        push_job.py[1] = ny;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            steps_reg  <= '0;
            errn_reg   <= '0;
            errp_reg   <= '0;
            dmaj_reg   <= '0;
            dmin_reg   <= '0;
            xneg_reg   <= 1'b0;
            yneg_reg   <= 1'b0;
            xmaj_reg   <= 1'b1;
            color_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            steps_reg  <= steps_next;
            errn_reg   <= errn_next;
            errp_reg   <= errp_next;
            dmaj_reg   <= dmaj_next;
            dmin_reg   <= dmin_next;
            xneg_reg   <= xneg_next;
            yneg_reg   <= yneg_next;
            xmaj_reg   <= xmaj_next;
            color_reg  <= color_next;
        end
    end

endmodule

/* sv/ysl_queue.sv */
// Short job queue between the front end and the point writer.
`timescale 1ns / 1ps

module ysl_queue import ysl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        push_job,
    input  logic        pop,
    output job_t        head,
    output queue_stat_t stat
);

    job_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/ysl_back.sv */
// Back end: expands jobs into results and computes the plane addresses.
`timescale 1ns / 1ps

module ysl_back import ysl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  geom_t                   geom,
    input  job_t                    head,
    input  queue_stat_t             q_stat,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // point_x, point_y, luma_addr, u_addr, v_addr, luma_out, cb_out, cr_out, zero pad
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // kind
    output logic [2:0]              m_axis_tuser,
    output logic                    m_axis_tlast
);

    logic                       en, issue, cur_last;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [2*COORD_W-1:0]       lprod_full;
    logic [2*COORD_W-3:0]       cprod_full;

    // stage 1: selected point
    logic                       s1_valid_reg;
    kind_t                      s1_kind_reg;
    logic                       s1_last_reg;
    logic [COORD_W-1:0]         s1_x_reg, s1_y_reg;
    logic [COLOR_W-1:0]         s1_color_reg;
    // stage 2: products
    logic                       s2_valid_reg;
    kind_t                      s2_kind_reg;
    logic                       s2_last_reg;
    logic [COORD_W-1:0]         s2_x_reg, s2_y_reg;
    logic [COLOR_W-1:0]         s2_color_reg;
    logic [ADDR_W-1:0]          s2_lprod_reg;
    logic [2*COORD_W-3:0]       s2_cprod_reg;
    // stage 3: luma address and chroma offset
    logic                       s3_valid_reg;
    kind_t                      s3_kind_reg;
    logic                       s3_last_reg;
    logic [COORD_W-1:0]         s3_x_reg, s3_y_reg;
    logic [COLOR_W-1:0]         s3_color_reg;
    logic [ADDR_W-1:0]          s3_laddr_reg, s3_chroma_reg;
    // output register
    logic                       out_valid_reg;
    kind_t                      out_kind_reg;
    logic                       out_last_reg;
    logic [COORD_W-1:0]         out_x_reg, out_y_reg;
    logic [COLOR_W-1:0]         out_color_reg;
    logic [ADDR_W-1:0]          out_laddr_reg, out_u_reg, out_v_reg;
    logic                       s3_is_point;

    assign en       = !out_valid_reg || m_axis_tready;
    assign issue    = en && !q_stat.empty;
    assign cur_last = idx_reg == head.cnt - 1'b1;
    assign pop      = issue && cur_last;
    assign idx_next = issue ? (cur_last ? '0 : idx_reg + 1'b1) : idx_reg;

    assign lprod_full  = s1_y_reg * geom.width;
    assign cprod_full  = s1_y_reg[COORD_W-1:1] * geom.width[COORD_W-1:1];
    assign s3_is_point = s3_kind_reg == KIND_POINT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (en)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg   <= head.kind;
            s1_last_reg   <= cur_last;
            s1_x_reg      <= head.px[idx_reg];
            s1_y_reg      <= head.py[idx_reg];
            s1_color_reg  <= head.color;

            s2_kind_reg   <= s1_kind_reg;
            s2_last_reg   <= s1_last_reg;
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_color_reg  <= s1_color_reg;
            s2_lprod_reg  <= lprod_full[ADDR_W-1:0];
            s2_cprod_reg  <= cprod_full;

            s3_kind_reg   <= s2_kind_reg;
            s3_last_reg   <= s2_last_reg;
            s3_x_reg      <= s2_x_reg;
            s3_y_reg      <= s2_y_reg;
            s3_color_reg  <= s2_color_reg;
            s3_laddr_reg  <= s2_lprod_reg + {{(ADDR_W-COORD_W){1'b0}}, s2_x_reg};
            s3_chroma_reg <= {1'b0, s2_cprod_reg}
                           + {{(ADDR_W-COORD_W+1){1'b0}}, s2_x_reg[COORD_W-1:1]};

            // status results carry zeros in every data field
            out_kind_reg  <= s3_kind_reg;
            out_last_reg  <= s3_last_reg;
            out_x_reg     <= s3_x_reg;
            out_y_reg     <= s3_y_reg;
            out_color_reg <= s3_color_reg;
            out_laddr_reg <= s3_is_point ? s3_laddr_reg : '0;
            out_u_reg     <= s3_is_point ? geom.size + s3_chroma_reg : '0;
            out_v_reg     <= s3_is_point ? geom.vbase + s3_chroma_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_color_reg[7:0], out_color_reg[15:8],
                            out_color_reg[23:16], out_v_reg, out_u_reg, out_laddr_reg,
                            out_y_reg, out_x_reg};

endmodule

/* sv/yuv420_supercover_line.sv */
// Supercover line generator for a planar YUV420 frame: top level.
//
// Draws a supercover (Bresenham with corner points) line into a YUV420 frame
// one major-axis step at a time. A load item (tuser 0) checks both endpoints
// against the width and height registers (a coordinate equal to the dimension
// is allowed) and answers with one result of kind "accepted" or "rejected". Each
// advance item (tuser 1) answers with the corner points of the step (none,
// one, or both when the error sits exactly on the diagonal) followed by the
// main point; the start point is never written, the end point is. An advance
// with no line gives "idle", one past the end gives "finished". Each point
// carries its luma, U and V byte addresses (modulo 2^25) and the colour bytes.
// Timing: the front end takes one item per clock while its four-entry job
// queue has room; the point writer issues one result per clock while the
// output accepts and the queue holds a job. A load or a plain step causes
// one result, a corner step up to three. The output port limits the rate.
// An accepted item passes the queue, point select, multiply, add and output
// register before its first result. A configuration write reaches the
// bounds check through the width and height registers; the derived plane
// size and V base follow through their own registers. tready on the input
// falls only when the job queue is full.
`timescale 1ns / 1ps
`include "yuv420_supercover_line_defines.svh"

module yuv420_supercover_line import ysl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // start_x, start_y, end_x, end_y, luma_in, cb_in, cr_in, zero pad
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                    s_axis_tuser,
    // result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // point_x, point_y, luma_addr, u_addr, v_addr, luma_out, cb_out, cr_out, zero pad
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // kind
    output logic [2:0]              m_axis_tuser,
    output logic                    m_axis_tlast,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [COORD_W-1:0]      cfg_data
);

    logic [COORD_W-1:0]     width_reg, width_next, height_reg, height_next;
    logic [ADDR_W-1:0]      size_reg, size_next, vbase_reg, vbase_next;
    logic [2*COORD_W-1:0]   size_full;
    logic [COORD_W-1:0]     cfg_sat;
    logic                   cfg_we;
    geom_t                  geom;

    logic                   push, pop;
    job_t                   push_job, head;
    queue_stat_t            q_stat;

    logic                   in_acc, status_out;

    // ---------------- configuration and frame geometry ----------------
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    // dimensions above the supported maximum saturate
    assign cfg_sat   = (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;

    assign width_next  = (cfg_we && cfg_index == REG_WIDTH)  ? cfg_sat : width_reg;
    assign height_next = (cfg_we && cfg_index == REG_HEIGHT) ? cfg_sat : height_reg;

    // luma plane size and V plane base, W*H and W*H + W*H/4
    assign size_full  = width_reg * height_reg;
    assign size_next  = size_full[ADDR_W-1:0];
    assign vbase_next = size_reg + {2'b00, size_reg[ADDR_W-1:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            size_reg   <= RESET_SIZE;
            vbase_reg  <= RESET_VBASE;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            size_reg   <= size_next;
            vbase_reg  <= vbase_next;
        end
    end

    assign geom.width  = width_reg;
    assign geom.height = height_reg;
    assign geom.size   = size_reg;
    assign geom.vbase  = vbase_reg;

    // ---------------- front end: accept and classify ----------------
    ysl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .geom          (geom),
        .q_stat        (q_stat),
        .push          (push),
        .push_job      (push_job)
    );

    // ---------------- job queue ----------------
    ysl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // ---------------- back end: points and addresses ----------------
    ysl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ---------------- assertions ----------------
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign status_out = m_axis_tvalid && (m_axis_tuser != KIND_POINT);

    `YSL_ASSERT_NEXT(a_push_lands, clk, rst_n, in_acc, q_stat.count != '0, "item not queued")
    `YSL_ASSERT_SAME(a_status_last, clk, rst_n, status_out, m_axis_tlast, "status without tlast")
    `YSL_ASSERT_SAME(a_status_zero, clk, rst_n, status_out, m_axis_tdata == '0, "status data set")

endmodule

/* test/yuv420_supercover_line_tb.sv */
// Self-checking testbench for the YUV420 supercover line generator.
`timescale 1ns / 1ps

module yuv420_supercover_line_tb;
    import ysl_pkg::*;

    // cycles with no accepted item on any channel before the run is abandoned
    localparam int STALL_LIMIT = 3000;
    // least number of items per random phase
    localparam int PHASE_ITEMS = 50;

    // one input item as the sender sees it
    typedef struct {
        action_t            act;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [7:0]         luma;
        logic [7:0]         cb;
        logic [7:0]         cr;
    } line_item_t;

    // one expected pixel write or status item
    typedef struct {
        kind_t              kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [ADDR_W-1:0]  luma_addr;
        logic [ADDR_W-1:0]  u_addr;
        logic [ADDR_W-1:0]  v_addr;
        logic [7:0]         luma;
        logic [7:0]         cb;
        logic [7:0]         cr;
        logic               last;
    } pixel_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = REG_WIDTH;
    logic [COORD_W-1:0]     cfg_data = '0;

    yuv420_supercover_line dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // items waiting to be sent, and pixel writes waiting to come out
    line_item_t   line_items[$];
    pixel_write_t expected_writes[$];

    int fails = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_stall = 0;
    bit in_quiet = 1'b0;
    bit out_quiet = 1'b0;
    bit in_taken = 1'b0;

    // ------------------------------------------------------------------
    // Line walker mirror: frame geometry and the latched line
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] frame_w = RESET_WIDTH;
    logic [COORD_W-1:0] frame_h = RESET_HEIGHT;
    logic               line_on = 1'b0;
    logic               neg_x = 1'b0;
    logic               neg_y = 1'b0;
    logic               x_major = 1'b1;
    logic [COORD_W-1:0] pos_x = '0;
    logic [COORD_W-1:0] pos_y = '0;
    logic [COORD_W-1:0] steps_rem = '0;
    logic [COORD_W-1:0] d_maj = '0;
    logic [COORD_W-1:0] d_min = '0;
    logic [ERR_W-1:0]   err_cur = '0;
    logic [ERR_W-1:0]   err_last = '0;
    logic [COLOR_W-1:0] colour = '0;

    function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v, input logic neg);
        return neg ? v - 1'b1 : v + 1'b1;
    endfunction

    function automatic pixel_write_t status_item(input kind_t k);
        pixel_write_t r;
        r = '{kind: k, px: '0, py: '0, luma_addr: '0, u_addr: '0, v_addr: '0,
              luma: '0, cb: '0, cr: '0, last: 1'b1};
        return r;
    endfunction

    // addresses into the planar frame; everything wraps at 2^25
    function automatic pixel_write_t pixel_at(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
        pixel_write_t r;
        longint unsigned w, plane, chroma;
        w = frame_w;
        plane = w * frame_h;
        chroma = longint'(y >> 1) * (w >> 1) + (x >> 1);
        r.kind = KIND_POINT;
        r.px = x;
        r.py = y;
        r.luma_addr = ADDR_W'(longint'(y) * w + x);
        r.u_addr = ADDR_W'(plane + chroma);
        r.v_addr = ADDR_W'(plane + plane / 4 + chroma);
        r.luma = colour[23:16];
        r.cb = colour[15:8];
        r.cr = colour[7:0];
        r.last = 1'b0;
        return r;
    endfunction

    // works out the results of one accepted item and queues them
    task automatic predict_line_item(input logic act, input logic [IN_DATA_W-1:0] d);
        logic [COORD_W-1:0] sx, sy, ex, ey, dx, dy, old_x, old_y;
        int unsigned two_maj, two_min, acc, diag;
        pixel_write_t step_q[$];
        sx = d[12:0];
        sy = d[25:13];
        ex = d[38:26];
        ey = d[51:39];
        if (act == ACT_LOAD)
        begin
            if (sx > frame_w || ex > frame_w || sy > frame_h || ey > frame_h)
            begin
                line_on = 1'b0;
                expected_writes.push_back(status_item(KIND_REJECT));
            end
            else
            begin
                neg_x = ex < sx;
                neg_y = ey < sy;
                dx = neg_x ? sx - ex : ex - sx;
                dy = neg_y ? sy - ey : ey - sy;
                x_major = dx >= dy;
                d_maj = x_major ? dx : dy;
                d_min = x_major ? dy : dx;
                err_cur = ERR_W'(d_maj);
                err_last = ERR_W'(d_maj);
                steps_rem = d_maj;
                pos_x = sx;
                pos_y = sy;
                // luma in the top byte, then U, then V
                colour = {d[59:52], d[67:60], d[75:68]};
                line_on = 1'b1;
                expected_writes.push_back(status_item(KIND_ACCEPT));
            end
        end
        else if (!line_on)
            expected_writes.push_back(status_item(KIND_IDLE));
        else if (steps_rem == 0)
        begin
            line_on = 1'b0;
            expected_writes.push_back(status_item(KIND_FINISH));
        end
        else
        begin
            two_maj = 2 * d_maj;
            two_min = 2 * d_min;
            old_x = pos_x;
            old_y = pos_y;
            if (x_major)
                pos_x = nudge(pos_x, neg_x);
            else
                pos_y = nudge(pos_y, neg_y);
            acc = err_cur + two_min;
            err_cur = acc[ERR_W-1:0];
            if (err_cur > two_maj)
            begin
                if (x_major)
                    pos_y = nudge(pos_y, neg_y);
                else
                    pos_x = nudge(pos_x, neg_x);
                err_cur = err_cur - ERR_W'(two_maj);
                diag = err_cur + err_last;
                // corner behind on the minor axis
                if (diag <= two_maj)
                    step_q.push_back(pixel_at(x_major ? pos_x : old_x,
                                              x_major ? old_y : pos_y));
                // corner behind on the major axis; both when exactly on the diagonal
                if (diag >= two_maj)
                    step_q.push_back(pixel_at(x_major ? old_x : pos_x,
                                              x_major ? pos_y : old_y));
            end
            step_q.push_back(pixel_at(pos_x, pos_y));
            step_q[step_q.size() - 1].last = 1'b1;
            err_last = err_cur;
            steps_rem = steps_rem - 1'b1;
            foreach (step_q[i])
                expected_writes.push_back(step_q[i]);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // mostly short gaps, now and then a long one; none at all in quiet stretches
    function automatic int gap_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender: feeds line_items, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        line_item_t nxt;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (in_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (line_items.size() > 0)
            begin
                nxt = line_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= nxt.act;
                s_axis_tdata <= {4'b0, nxt.cr, nxt.cb, nxt.luma, nxt.ey, nxt.ex, nxt.sy, nxt.sx};
                in_gap <= gap_len(in_quiet);
                if ($urandom_range(0, 99) < 4)
                    in_quiet <= !in_quiet;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure on the result side
    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                out_stall <= gap_len(out_quiet);
            if ($urandom_range(0, 199) == 0)
                out_quiet <= !out_quiet;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, tracks accepted items and register writes,
    // and keeps the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_write_t want;
        bit moved;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected result item, kind %0d", m_axis_tuser);
                    fails++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("point_x", want.px, m_axis_tdata[12:0]);
                    check_field("point_y", want.py, m_axis_tdata[25:13]);
                    check_field("luma_addr", want.luma_addr, m_axis_tdata[50:26]);
                    check_field("u_addr", want.u_addr, m_axis_tdata[75:51]);
                    check_field("v_addr", want.v_addr, m_axis_tdata[100:76]);
                    check_field("luma_out", want.luma, m_axis_tdata[108:101]);
                    check_field("cb_out", want.cb, m_axis_tdata[116:109]);
                    check_field("cr_out", want.cr, m_axis_tdata[124:117]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                predict_line_item(s_axis_tuser, s_axis_tdata);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                if (cfg_index == REG_WIDTH)
                    frame_w = clamp_dim(cfg_data);
                else if (cfg_index == REG_HEIGHT)
                    frame_h = clamp_dim(cfg_data);
            end
            if (moved)
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("yuv420_supercover_line_tb NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic line_item_t load_item(input int sx, input int sy, input int ex,
                                             input int ey, input int l, input int u,
                                             input int v);
        line_item_t it;
        it = '{act: ACT_LOAD, sx: COORD_W'(sx), sy: COORD_W'(sy), ex: COORD_W'(ex),
               ey: COORD_W'(ey), luma: 8'(l), cb: 8'(u), cr: 8'(v)};
        return it;
    endfunction

    // advance item; its other fields are don't-care, so fill them with noise
    function automatic line_item_t step_item();
        line_item_t it;
        it = load_item($urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        it.act = ACT_STEP;
        return it;
    endfunction

    task automatic add_steps(input int n);
        repeat (n)
            line_items.push_back(step_item());
    endtask

    // coordinate inside 0..dim, leaning towards the edges
    function automatic int coord_in(input int dim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 20)
            return dim;
        return $urandom_range(0, dim);
    endfunction

    function automatic int near_coord(input int c, input int dim, input int span);
        int v;
        v = c + $signed($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > dim)
            v = dim;
        return v;
    endfunction

    // a phase of random traffic for the given frame
    task automatic add_random_phase(input int w, input int h);
        int added, r, span, sx, sy, ex, ey, dmaj, n;
        line_item_t it;
        added = 0;
        while (added < PHASE_ITEMS)
        begin
            r = $urandom_range(0, 99);
            span = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
            sx = coord_in(w);
            sy = coord_in(h);
            ex = near_coord(sx, w, span);
            ey = near_coord(sy, h, span);
            if ($urandom_range(0, 9) == 0)
                ey = sy;
            else if ($urandom_range(0, 9) == 0)
                ex = sx;
            it = load_item(sx, sy, ex, ey, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            if (r < 70)
            begin
                // well-formed line walked to its end, sometimes cut short, sometimes stepped once past it
                dmaj = (ex > sx ? ex - sx : sx - ex);
                if ((ey > sy ? ey - sy : sy - ey) > dmaj)
                    dmaj = (ey > sy ? ey - sy : sy - ey);
                n = dmaj + 1;
                r = $urandom_range(0, 99);
                if (r < 12)
                    n = $urandom_range(0, dmaj);
                else if (r < 27)
                    n = n + 1;
                line_items.push_back(it);
                add_steps(n);
                added += n + 1;
            end
            else if (r < 80)
            begin
                // one endpoint pushed outside the frame
                case ($urandom_range(0, 3))
                    0: it.sx = COORD_W'($urandom_range(w + 1, 8191));
                    1: it.sy = COORD_W'($urandom_range(h + 1, 8191));
                    2: it.ex = COORD_W'($urandom_range(w + 1, 8191));
                    default: it.ey = COORD_W'($urandom_range(h + 1, 8191));
                endcase
                line_items.push_back(it);
                added++;
            end
            else if (r < 90)
            begin
                add_steps(1);
                added++;
            end
            else
            begin
                it = step_item();
                it.act = ACT_LOAD;
                line_items.push_back(it);
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (line_items.size() != 0 || s_axis_tvalid || expected_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= COORD_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reprogram the frame once the block has gone quiet
    task automatic set_frame(input int w, input int h);
        wait_drained();
        repeat (8) @(posedge clk);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        // plane size lags the register, since size and V base are registered from it
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int w, h;

        // directed part on the reset frame, 352 x 288
        add_steps(1);                                               // no line yet
        line_items.push_back(load_item(0, 0, 352, 288, 8'h00, 8'hFF, 8'h80));
        add_steps(2);
        line_items.push_back(load_item(353, 0, 0, 0, 1, 2, 3));     // x past the edge
        add_steps(1);                                               // reject cleared the line
        line_items.push_back(load_item(8191, 8191, 8191, 8191, 255, 255, 255));
        line_items.push_back(load_item(0, 0, 0, 289, 9, 9, 9));     // y past the edge
        line_items.push_back(load_item(5, 5, 5, 5, 10, 20, 30));    // zero length
        add_steps(2);                                               // finished, then idle
        line_items.push_back(load_item(10, 10, 13, 13, 40, 50, 60)); // on the diagonal
        add_steps(4);
        line_items.push_back(load_item(20, 10, 14, 8, 70, 80, 90)); // both axes backwards
        add_steps(2);
        line_items.push_back(load_item(3, 7, 5, 0, 1, 128, 254));   // y major, replaces line
        add_steps(2);
        line_items.push_back(load_item(0, 0, 3, 2, 77, 88, 99));    // corner behind on minor
        add_steps(2);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_frame(2, 2);
        add_random_phase(2, 2);
        set_frame(4096, 4096);
        add_random_phase(4096, 4096);
        set_frame(8191, 3);                                         // width saturates
        add_random_phase(4096, 3);
        set_frame(33, 8191);                                        // odd width, height saturates
        add_random_phase(33, 4096);
        w = $urandom_range(2, 4096);
        h = $urandom_range(2, 300);
        set_frame(w, h);
        add_random_phase(w, h);
        set_frame(351, 287);
        add_random_phase(351, 287);

        wait_drained();
        repeat (30) @(posedge clk);
        if (fails == 0 && expected_writes.size() == 0)
            $display("yuv420_supercover_line_tb OK");
        else
            $display("yuv420_supercover_line_tb NOT OK");
        $finish;
    end

endmodule
